/* src/pvs_pkg.sv */
// types and constants shared by the purge valve sequencer
`timescale 1ns / 1ps
package pvs_pkg;

  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] PurgeLengthReset = 16'd1000;
  localparam logic [CountW-1:0] PurgePeriodReset = 16'd15000;

  typedef enum logic {
    REG_PURGE_LENGTH = 1'b0,
    REG_PURGE_PERIOD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CountW-1:0] purge_length_ms;
    logic [CountW-1:0] purge_period_ms;
  } cfg_t;

  typedef struct packed {
    logic supply_valve;
    logic purge_valve;
    logic run_led;
  } result_t;

endpackage

/* src/pvs_in_if.sv */
// input channel carrying one tick item
`timescale 1ns / 1ps
interface pvs_in_if;
  logic valid;
  logic ready;
  logic active;

  modport source (output valid, output active, input ready);
  modport sink (input valid, input active, output ready);
endinterface

/* src/pvs_out_if.sv */
// output channel carrying one valve result item
`timescale 1ns / 1ps
interface pvs_out_if;
  logic valid;
  logic ready;
  logic supply_valve;
  logic purge_valve;
  logic run_led;

  modport source (output valid, output supply_valve, output purge_valve, output run_led,
                  input ready);
  modport sink (input valid, input supply_valve, input purge_valve, input run_led,
                output ready);
endinterface

/* src/pvs_core.sv */
// sequence state registers and per-tick valve logic
`timescale 1ns / 1ps
module pvs_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            active_i,
  input  pvs_pkg::cfg_t    cfg_i,
  output pvs_pkg::result_t result_o
);
  import pvs_pkg::*;

  localparam logic [1:0] PhStandby = 2'd0;
  localparam logic [1:0] PhStartup = 2'd1;
  localparam logic [1:0] PhRunning = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [CountW-1:0] pulse_q, pulse_d;
  logic [CountW-1:0] period_q, period_d;

  always_comb begin
    logic [1:0]        ph;
    logic [CountW-1:0] pulse;
    logic [CountW-1:0] per;
    result_o = '0;
    ph       = phase_q;
    pulse    = pulse_q;
    per      = period_q;
    if (!active_i) begin
      ph    = PhStandby;
      pulse = '0;
      per   = '0;
    end else begin
      result_o.supply_valve = 1'b1;
      if (ph != PhStartup && ph != PhRunning) begin
        ph    = PhStartup;
        pulse = cfg_i.purge_length_ms;
        per   = '0;
      end
      if (ph == PhStartup) begin
        if (pulse != '0) begin
          result_o.purge_valve = 1'b1;
          pulse = pulse - 1'b1;
        end else begin
          ph = PhRunning;
          per = '0;
          result_o.run_led = 1'b1;
        end
      end else begin
        per = per + 1'b1;
        if (per >= cfg_i.purge_period_ms) begin
          per   = '0;
          pulse = cfg_i.purge_length_ms;
        end
        if (pulse != '0) begin
          result_o.purge_valve = 1'b1;
          pulse = pulse - 1'b1;
        end
        result_o.run_led = 1'b1;
      end
    end
    phase_d  = ph;
    pulse_d  = pulse;
    period_d = per;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStandby;
      pulse_q  <= '0;
      period_q <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      pulse_q  <= pulse_d;
      period_q <= period_d;
    end
  end

endmodule

/* src/pvs_out_reg.sv */
// result register driving the output channel
`timescale 1ns / 1ps
module pvs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pvs_pkg::result_t result_i,
  output logic             free_o,
  pvs_out_if.source        out_o
);
  import pvs_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || out_o.ready;
  assign vld_d  = load_i || (vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.supply_valve = res_q.supply_valve;
  assign out_o.purge_valve  = res_q.purge_valve;
  assign out_o.run_led      = res_q.run_led;

endmodule

/* src/purge_valve_sequencer_unit.sv */
// top level of the purge valve sequencer
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   active
//   out_o    out  valid/ready   supply_valve, purge_valve, run_led
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; from input to result
// an item passes the input register, then the result register after the state update
// reset returns to standby and loads the default length and period
// a stalled output holds the result and the input register; one item waits in each
`timescale 1ns / 1ps
module purge_valve_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pvs_pkg::CountW-1:0]   cfg_data_i,
  pvs_in_if.sink                       in_i,
  pvs_out_if.source                    out_o
);
  import pvs_pkg::*;

  cfg_t    cfg_q;
  logic    in_vld_q;
  logic    active_q;
  logic    free;
  logic    adv;
  result_t result;

  assign adv        = in_vld_q && free;
  assign in_i.ready = !in_vld_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.purge_length_ms <= PurgeLengthReset;
      cfg_q.purge_period_ms <= PurgePeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PURGE_LENGTH: cfg_q.purge_length_ms <= cfg_data_i;
        REG_PURGE_PERIOD: cfg_q.purge_period_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      active_q <= in_i.active;
    end
  end

  pvs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .active_i (active_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  pvs_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule
